>>> rtl/encoder_event_speed_estimator_macros.svh
// assertion macros shared by the encoder event speed estimator rtl
`ifndef ENCODER_EVENT_SPEED_ESTIMATOR_MACROS_SVH
`define ENCODER_EVENT_SPEED_ESTIMATOR_MACROS_SVH

// condition implies property in the same cycle
`define EES_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// condition implies property in the next cycle
`define EES_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

// property holds at every clock edge
`define EES_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

>>> rtl/ees_pkg.sv
// shared widths, constants and types of the encoder event speed estimator
package ees_pkg;

   localparam int TimeW     = 40;
   localparam int SpeedW    = 32;
   localparam int ThrW      = 20;
   localparam int TripsW    = 8;
   localparam int LagW      = 4;
   localparam int DenW      = TripsW + TimeW;
   localparam int ReqDataW  = 40;
   localparam int RspDataW  = 72;
   localparam int CsrAddrW  = 4;
   localparam int CsrDataW  = 32;

   localparam logic [SpeedW-1:0] SpeedMax = '1;

   typedef enum logic [1:0] {
      REG_CLOSE_THRESHOLD = 2'd0,
      REG_PULSES_PER_REV  = 2'd1,
      REG_SPEED_LAG       = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [ThrW-1:0]   close_threshold;
      logic [TripsW-1:0] pulses_per_rev;
      logic [LagW-1:0]   speed_lag;
   } cfg_type;

   typedef struct packed {
      logic              done;
      logic              saturated;
      logic [SpeedW-1:0] quotient;
   } div_status_type;

endpackage

>>> rtl/ees_csr.sv
// apb configuration registers of the encoder event speed estimator
module ees_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ees_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [ees_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [ees_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                          csr_pready,
   output ees_pkg::cfg_type              cfg
);

   localparam logic [ees_pkg::ThrW-1:0]   ThrReset   = 20'd1000;
   localparam logic [ees_pkg::TripsW-1:0] TripsReset = 8'd12;
   localparam logic [ees_pkg::LagW-1:0]   LagReset   = 4'd2;

   ees_pkg::reg_index_type        index;
   logic                          wr_en;
   logic [ees_pkg::ThrW-1:0]      thr_ff, thr_in;
   logic [ees_pkg::TripsW-1:0]    trips_ff, trips_in;
   logic [ees_pkg::LagW-1:0]      lag_ff, lag_in;

   assign csr_pready = 1'b1;
   assign index      = ees_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      thr_in   = thr_ff;
      trips_in = trips_ff;
      lag_in   = lag_ff;
      if (wr_en) begin
         case (index)
            ees_pkg::REG_CLOSE_THRESHOLD: thr_in = csr_pwdata[ees_pkg::ThrW-1:0];
            ees_pkg::REG_PULSES_PER_REV:  trips_in = csr_pwdata[ees_pkg::TripsW-1:0];
            ees_pkg::REG_SPEED_LAG:       lag_in = csr_pwdata[ees_pkg::LagW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         ees_pkg::REG_CLOSE_THRESHOLD: csr_prdata = ees_pkg::CsrDataW'(thr_ff);
         ees_pkg::REG_PULSES_PER_REV:  csr_prdata = ees_pkg::CsrDataW'(trips_ff);
         ees_pkg::REG_SPEED_LAG:       csr_prdata = ees_pkg::CsrDataW'(lag_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= ThrReset;
         trips_ff <= TripsReset;
         lag_ff   <= LagReset;
      end else begin
         thr_ff   <= thr_in;
         trips_ff <= trips_in;
         lag_ff   <= lag_in;
      end
   end

   assign cfg.close_threshold = thr_ff;
   assign cfg.pulses_per_rev  = trips_ff;
   assign cfg.speed_lag       = lag_ff;

endmodule

>>> rtl/ees_divider.sv
// bit-serial restoring divider with 32-bit quotient and saturation check
module ees_divider #(
   parameter int NumW = 53
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NumW-1:0]              num,
   input  logic [ees_pkg::DenW-1:0]     den,
   output ees_pkg::div_status_type      status
);

   localparam int QW   = ees_pkg::SpeedW;
   localparam int DW   = ees_pkg::DenW;
   localparam int HiW  = NumW - QW;
   localparam int CmpW = (HiW > DW) ? HiW : DW;
   localparam int CntW = $clog2(QW);

   logic [CmpW-1:0] hi_ext;
   logic            sat_now;
   logic [DW:0]     shifted;
   logic [DW:0]     diff;
   logic            ge;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff;
   logic            sat_ff;
   logic [DW-1:0]   rem_ff;
   logic [DW-1:0]   den_ff;
   logic [QW-1:0]   lo_ff;
   logic [QW-1:0]   quo_ff;

   assign hi_ext  = CmpW'(num[NumW-1:QW]);
   assign sat_now = hi_ext >= CmpW'(den);
   assign shifted = {rem_ff, lo_ff[QW-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = !sat_now;
         done_in = sat_now;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sat_ff <= sat_now;
         rem_ff <= hi_ext[DW-1:0];
         den_ff <= den;
         lo_ff  <= num[QW-1:0];
         quo_ff <= '0;
         cnt_ff <= CntW'(QW - 1);
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DW-1:0] : shifted[DW-1:0];
         lo_ff  <= {lo_ff[QW-2:0], 1'b0};
         quo_ff <= {quo_ff[QW-2:0], ge};
         cnt_ff <= cnt_ff - CntW'(1);
      end
   end

   assign status.done      = done_ff;
   assign status.saturated = sat_ff;
   assign status.quotient  = quo_ff;

endmodule

>>> rtl/ees_core.sv
// event filter, history memory, interval arithmetic and result register
`include "encoder_event_speed_estimator_macros.svh"

module ees_core #(
   parameter int MAX_LAG          = 8,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ees_pkg::cfg_type              cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ees_pkg::ReqDataW-1:0]  req_tdata,
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ees_pkg::RspDataW-1:0]  rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   localparam int TW    = ees_pkg::TimeW;
   localparam int PtrW  = $clog2(MAX_LAG);
   localparam int CntW  = $clog2(MAX_LAG + 1);
   localparam int TpsW  = $clog2(TICKS_PER_SECOND + 1);
   localparam int ProdW = CntW + TpsW;
   localparam int NumW  = (ProdW + 16 > 33) ? ProdW + 16 : 33;
   localparam int LCW   = (CntW > ees_pkg::LagW) ? CntW : ees_pkg::LagW;
   localparam int IW    = CntW + 1;
   localparam int MinLag = 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DT,
      S_MUL,
      S_DIVST,
      S_DIV,
      S_EMIT0,
      S_EMIT1
   } state_type;

   state_type state_ff, state_in;
   logic      seen_ff, seen_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] ptr_ff, ptr_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [TW-1:0]   t_ff;
   logic [TW-1:0]   prev_ff;
   logic [CntW-1:0] m_ff;
   logic            count_one_ff;
   logic [TW-1:0]   dt_ff;
   logic            dt_bad_ff;
   logic [TW-1:0]   back_ff;
   logic [NumW-1:0] num_ff;
   logic [ees_pkg::DenW-1:0] den_ff;
   logic [ees_pkg::SpeedW-1:0] speed_ff;
   logic            bad_ff;
   logic [ees_pkg::SpeedW-1:0] out_speed_ff;
   logic [TW-1:0]   out_time_ff;
   logic            out_bad_ff;
   logic            out_last_ff;

   logic [TW-1:0]   hist_mem [MAX_LAG];
   logic [TW-1:0]   rd_data_ff;

   logic            accept;
   logic            out_free;
   logic            out_load;
   logic            out_last;
   logic            mem_we;
   logic            div_start;
   logic [PtrW-1:0] ptr_next;
   logic [CntW-1:0] count_next;
   logic [TW:0]     fwd, bwd, dt_raw;
   logic [TW-1:0]   mag;
   logic            close;
   logic [LCW-1:0]  lag_ext, lag_eff, count_ext, m_ext;
   logic [CntW-1:0] m;
   logic [IW-1:0]   ptr_iw, m_iw, idx_sum;
   logic [PtrW-1:0] raddr;
   logic [ees_pkg::TripsW-1:0] trips_eff;
   logic [ProdW-1:0] prod;
   ees_pkg::div_status_type div_status;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ptr_next   = (ptr_ff == PtrW'(MAX_LAG - 1)) ? '0 : ptr_ff + PtrW'(1);
   assign count_next = (count_ff == CntW'(MAX_LAG)) ? count_ff : count_ff + CntW'(1);

   // double trip check against the previous raw event
   assign fwd   = {1'b0, t_ff} - {1'b0, prev_ff};
   assign bwd   = {1'b0, prev_ff} - {1'b0, t_ff};
   assign mag   = fwd[TW] ? bwd[TW-1:0] : fwd[TW-1:0];
   assign close = mag < TW'(cfg.close_threshold);

   // events spanned by this interval
   always_comb begin
      lag_ext   = LCW'(cfg.speed_lag);
      count_ext = LCW'(count_ff);
      if (lag_ext < LCW'(MinLag)) begin
         lag_eff = LCW'(MinLag);
      end else if (lag_ext > LCW'(MAX_LAG)) begin
         lag_eff = LCW'(MAX_LAG);
      end else begin
         lag_eff = lag_ext;
      end
      m_ext = (count_ext < lag_eff) ? count_ext : lag_eff;
   end
   assign m = m_ext[CntW-1:0];

   // history slot m places back
   assign ptr_iw  = IW'(ptr_ff);
   assign m_iw    = IW'(m);
   assign idx_sum = (ptr_iw >= m_iw) ? ptr_iw - m_iw : ptr_iw + IW'(MAX_LAG) - m_iw;
   assign raddr   = idx_sum[PtrW-1:0];

   assign dt_raw    = {1'b0, t_ff} - {1'b0, rd_data_ff};
   assign trips_eff = (cfg.pulses_per_rev == '0) ? ees_pkg::TripsW'(1) : cfg.pulses_per_rev;
   assign prod      = ProdW'(m_ff) * ProdW'(TICKS_PER_SECOND);

   always_comb begin
      state_in     = state_ff;
      seen_in      = seen_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      out_last     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
               if (req_tuser) begin
                  seen_in  = 1'b0;
                  count_in = '0;
                  ptr_in   = '0;
               end
            end
         end
         S_CHECK: begin
            if (!seen_ff) begin
               state_in = S_IDLE;
               if (t_ff != '0) begin
                  seen_in  = 1'b1;
                  mem_we   = 1'b1;
                  ptr_in   = ptr_next;
                  count_in = count_next;
               end
            end else if (close) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_DT;
            end
         end
         S_DT: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (dt_bad_ff) begin
               state_in = count_one_ff ? S_EMIT0 : S_EMIT1;
            end else begin
               state_in = S_DIVST;
            end
         end
         S_DIVST: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               state_in = count_one_ff ? S_EMIT0 : S_EMIT1;
            end
         end
         S_EMIT0: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_EMIT1;
            end
         end
         S_EMIT1: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               mem_we   = 1'b1;
               ptr_in   = ptr_next;
               count_in = count_next;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff <= req_tdata[TW-1:0];
      end
      if (state_ff == S_CHECK && (seen_ff || t_ff != '0)) begin
         prev_ff <= t_ff;
      end
      if (state_ff == S_CHECK) begin
         m_ff         <= m;
         count_one_ff <= (count_ff == CntW'(1));
      end
      if (state_ff == S_DT) begin
         dt_ff     <= dt_raw[TW-1:0];
         dt_bad_ff <= dt_raw[TW] || (dt_raw == '0);
         back_ff   <= rd_data_ff;
         num_ff    <= NumW'({prod, 16'b0});
      end
      if (state_ff == S_MUL) begin
         den_ff <= ees_pkg::DenW'(trips_eff) * ees_pkg::DenW'(dt_ff);
         if (dt_bad_ff) begin
            speed_ff <= ees_pkg::SpeedMax;
            bad_ff   <= 1'b1;
         end
      end
      if (state_ff == S_DIV && div_status.done) begin
         speed_ff <= div_status.saturated ? ees_pkg::SpeedMax : div_status.quotient;
         bad_ff   <= div_status.saturated;
      end
      if (out_load) begin
         out_speed_ff <= speed_ff;
         out_time_ff  <= out_last ? t_ff : back_ff;
         out_bad_ff   <= bad_ff;
         out_last_ff  <= out_last;
      end
   end

   // time history, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[ptr_ff] <= t_ff;
      end
      rd_data_ff <= hist_mem[raddr];
   end

   ees_divider #(
      .NumW (NumW)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num_ff),
      .den    (den_ff),
      .status (div_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_time_ff, out_speed_ff};
   assign rsp_tuser  = out_bad_ff;
   assign rsp_tlast  = out_last_ff;

   `EES_ASSERT_SAME(a_seen_has_history, clock, reset, state_ff == S_CHECK && seen_ff, count_ff != '0, "history empty after first event")
   `EES_ASSERT_ALWAYS(a_count_bound, clock, reset, 32'(count_ff) <= MAX_LAG, "accepted count beyond max lag")
   `EES_ASSERT_ALWAYS(a_ptr_bound, clock, reset, 32'(ptr_ff) < MAX_LAG, "history pointer out of range")
   `EES_ASSERT_SAME(a_div_done_state, clock, reset, div_status.done, state_ff == S_DIV, "divider finished outside wait state")
   `EES_ASSERT_NEXT(a_final_pushes, clock, reset, state_ff == S_EMIT1 && out_free, rsp_valid_ff && rsp_tlast && count_ff != '0, "final item not marked or not pushed")

endmodule

>>> rtl/encoder_event_speed_estimator.sv
// Encoder event speed estimator, top level.
// req channel: one encoder trip timestamp per item; tuser marks the first event of a record
// and clears the event history before that event is handled.
// rsp channel: speed in Q16.16 revolutions per second with the accepted event time; tuser
// flags a zero or negative interval or a saturated speed, tlast marks the final item that
// one input caused. The second accepted event of a record gives two items, the first with the earlier event time.
// csr port: close_threshold at 0x0, pulses_per_rev at 0x4, speed_lag at 0x8.
// Timing: a zero event before the first one of a record, a duplicate or a first event is
// taken with no result. An accepted event's result is set by the 32-step serial divider,
// and no new item is taken until the previous one has loaded its last result; a quotient
// that saturates is known when the divider starts, so its result comes without the serial
// steps; a bad interval skips the divider altogether.
// The history lives in a MAX_LAG entry memory with registered read and one write port.
// Reset: registers return to 1000 / 12 / 2, history is empty, no item is pending.
// Stall: a result waits in the output register while rsp_tready is low; the next input
// item is still taken, and its own result waits until the register is free.
module encoder_event_speed_estimator #(
   parameter int MAX_LAG          = 8,
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ees_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [ees_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [ees_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                          csr_pready,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ees_pkg::ReqDataW-1:0]  req_tdata,   // event_time
   input  logic                          req_tuser,   // record_start
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ees_pkg::RspDataW-1:0]  rsp_tdata,   // speed_q16, accepted_time
   output logic                          rsp_tuser,   // bad_interval
   output logic                          rsp_tlast
);

   ees_pkg::cfg_type cfg;

   ees_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ees_core #(
      .MAX_LAG          (MAX_LAG),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
